// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, cond, prop)

`define ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// ===== rtl/rsd_pkg.sv =====
package rsd_pkg;

  localparam int INDEX_WIDTH     = 10;
  localparam int COUNT_WIDTH     = 11;
  localparam int LIMIT_WIDTH     = 48;
  localparam int STILL_WIDTH     = 32;
  localparam int STEP_WIDTH      = 16;
  localparam int CFG_DATA_WIDTH  = 48;
  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [1:0] {
    ACT_REST     = 2'd0,
    ACT_WAKE     = 2'd1,
    ACT_WAKE_ALL = 2'd2
  } action_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_ROD_COUNT     = 3'd0,
    CFG_LIN_LIMIT     = 3'd1,
    CFG_ANG_LIMIT     = 3'd2,
    CFG_STILL_LIMIT   = 3'd3,
    CFG_TIME_STEP     = 3'd4
  } cfg_reg_t;

endpackage

// ===== rtl/rsd_ram.sv =====
module rsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rsd_rest_check.sv =====
module rsd_rest_check
  import rsd_pkg::*;
#(
  parameter int SPEED_WIDTH = 24
) (
  input  logic                          clk,
  input  logic signed [SPEED_WIDTH-1:0] vel_x,
  input  logic signed [SPEED_WIDTH-1:0] vel_y,
  input  logic signed [SPEED_WIDTH-1:0] vel_z,
  input  logic signed [SPEED_WIDTH-1:0] spin_x,
  input  logic signed [SPEED_WIDTH-1:0] spin_y,
  input  logic signed [SPEED_WIDTH-1:0] spin_z,
  input  logic [LIMIT_WIDTH-1:0]        lin_limit,
  input  logic [LIMIT_WIDTH-1:0]        ang_limit,
  output logic                          rest_ok
);

  localparam int SQW  = 2 * SPEED_WIDTH;
  localparam int SUMW = SQW + 2;
  localparam int CMPW = (SUMW > LIMIT_WIDTH) ? SUMW : LIMIT_WIDTH;

  logic [SQW-1:0]  sq_vx, sq_vy, sq_vz, sq_sx, sq_sy, sq_sz;
  logic [CMPW-1:0] lin_sum, ang_sum;

  // square each component
  always_ff @(posedge clk) begin
    sq_vx <= SQW'(vel_x * vel_x);
    sq_vy <= SQW'(vel_y * vel_y);
    sq_vz <= SQW'(vel_z * vel_z);
    sq_sx <= SQW'(spin_x * spin_x);
    sq_sy <= SQW'(spin_y * spin_y);
    sq_sz <= SQW'(spin_z * spin_z);
  end

  always_comb begin
    lin_sum = CMPW'(sq_vx) + CMPW'(sq_vy) + CMPW'(sq_vz);
    ang_sum = CMPW'(sq_sx) + CMPW'(sq_sy) + CMPW'(sq_sz);
  end

  always_ff @(posedge clk) begin
    rest_ok <= (lin_sum < CMPW'(lin_limit)) && (ang_sum < CMPW'(ang_limit));
  end

endmodule

// ===== rtl/rest_sleep_detector_unit.sv =====
// Channel  | Handshake          | Payload
// in       | in_valid, in_stall | action, rod_index, vel_x/y/z, spin_x/y/z
// out      | out_valid, out_stall | out_rod_index, asleep, still_time
// cfg      | cfg_we             | cfg_index, cfg_data
// An item goes through accept with memory read, square, compare and write back, in order.
// The two register stages of the speed check lie ahead of the write-back.
// After reset and after each wake-all beat the whole memory is swept to zero,
// with in_stall high. A result waiting under out_stall holds the write-back stage.
module rest_sleep_detector_unit
  import rsd_pkg::*;
#(
  parameter int MAX_RODS    = 1024,
  parameter int SPEED_WIDTH = 24,
  parameter int TIMER_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic [INDEX_WIDTH-1:0]        rod_index,
  input  logic signed [SPEED_WIDTH-1:0] vel_x,
  input  logic signed [SPEED_WIDTH-1:0] vel_y,
  input  logic signed [SPEED_WIDTH-1:0] vel_z,
  input  logic signed [SPEED_WIDTH-1:0] spin_x,
  input  logic signed [SPEED_WIDTH-1:0] spin_y,
  input  logic signed [SPEED_WIDTH-1:0] spin_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [INDEX_WIDTH-1:0]        out_rod_index,
  output logic                          asleep,
  output logic [STILL_WIDTH-1:0]        still_time
);

`include "assert_macros.svh"

  localparam int AW  = (MAX_RODS > 1) ? $clog2(MAX_RODS) : 1;
  localparam int IW  = (AW > INDEX_WIDTH) ? AW : INDEX_WIDTH;
  localparam int EW  = TIMER_WIDTH + 1;
  localparam int CW  = ((TIMER_WIDTH > STILL_WIDTH) ? TIMER_WIDTH : STILL_WIDTH) + 1;
  localparam logic [CW-1:0] TIMER_MAX =
    {{(CW-TIMER_WIDTH){1'b0}}, {TIMER_WIDTH{1'b1}}};
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_RODS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_WRITE,
    ST_CLEAR
  } state_t;

  state_t state;

  logic [COUNT_WIDTH-1:0] rod_count;
  logic [LIMIT_WIDTH-1:0] lin_limit, ang_limit;
  logic [STILL_WIDTH-1:0] still_limit;
  logic [STEP_WIDTH-1:0]  time_step;

  logic [1:0]                    action_q;
  logic [INDEX_WIDTH-1:0]        index_q;
  logic signed [SPEED_WIDTH-1:0] vx_q, vy_q, vz_q, sx_q, sy_q, sz_q;

  logic [AW-1:0] clr_cnt;

  logic          in_accept, out_take, wr_go;
  logic          rest_ok;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic [IW-1:0]          raddr_wide, addr_wide;
  logic                   in_mem, in_use;
  logic [TIMER_WIDTH-1:0] t_old, t_new;
  logic [CW-1:0]          t_sum;
  logic                   f_old, f_new;
  logic                   res_flag;
  logic [TIMER_WIDTH-1:0] res_timer;
  logic                   entry_we;
  logic [EW-1:0]          entry_data;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign wr_go     = (state == ST_WRITE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rod_count   <= '0;
      lin_limit   <= '0;
      ang_limit   <= '0;
      still_limit <= '0;
      time_step   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ROD_COUNT:   rod_count   <= cfg_data[COUNT_WIDTH-1:0];
        CFG_LIN_LIMIT:   lin_limit   <= cfg_data[LIMIT_WIDTH-1:0];
        CFG_ANG_LIMIT:   ang_limit   <= cfg_data[LIMIT_WIDTH-1:0];
        CFG_STILL_LIMIT: still_limit <= cfg_data[STILL_WIDTH-1:0];
        CFG_TIME_STEP:   time_step   <= cfg_data[STEP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      action_q <= action;
      index_q  <= rod_index;
      vx_q     <= vel_x;
      vy_q     <= vel_y;
      vz_q     <= vel_z;
      sx_q     <= spin_x;
      sy_q     <= spin_y;
      sz_q     <= spin_z;
    end
  end

  rsd_rest_check #(
    .SPEED_WIDTH(SPEED_WIDTH)
  ) u_rest_check (
    .clk      (clk),
    .vel_x    (vx_q),
    .vel_y    (vy_q),
    .vel_z    (vz_q),
    .spin_x   (sx_q),
    .spin_y   (sy_q),
    .spin_z   (sz_q),
    .lin_limit(lin_limit),
    .ang_limit(ang_limit),
    .rest_ok  (rest_ok)
  );

  always_comb begin
    raddr_wide = IW'(rod_index);
    addr_wide  = IW'(index_q);
    ram_raddr  = raddr_wide[AW-1:0];
    ram_re     = in_accept;
    in_mem     = (32'(index_q) < MAX_RODS);
    in_use     = in_mem && ({1'b0, index_q} < rod_count);
    t_old      = ram_rdata[TIMER_WIDTH-1:0];
    f_old      = ram_rdata[TIMER_WIDTH];
    t_sum      = CW'(t_old) + CW'(time_step);
    t_new      = (t_sum > TIMER_MAX) ? TIMER_MAX[TIMER_WIDTH-1:0] : t_sum[TIMER_WIDTH-1:0];
    f_new      = f_old || (CW'(t_new) >= CW'(still_limit));
    entry_we   = 1'b0;
    entry_data = '0;
    res_flag   = 1'b0;
    res_timer  = '0;
    case (action_t'(action_q))
      ACT_REST: begin
        if (in_use) begin
          entry_we   = 1'b1;
          entry_data = rest_ok ? {f_new, t_new} : '0;
          res_flag   = entry_data[TIMER_WIDTH];
          res_timer  = entry_data[TIMER_WIDTH-1:0];
        end else if (in_mem) begin
          res_flag  = f_old;
          res_timer = t_old;
        end
      end
      ACT_WAKE: begin
        if (in_use) begin
          entry_we = 1'b1;
        end else if (in_mem) begin
          res_flag  = f_old;
          res_timer = t_old;
        end
      end
      ACT_WAKE_ALL: ;
      default: begin
        if (in_mem) begin
          res_flag  = f_old;
          res_timer = t_old;
        end
      end
    endcase
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = wr_go && entry_we;
      ram_waddr = addr_wide[AW-1:0];
      ram_wdata = entry_data;
    end
  end

  rsd_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_RODS)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_take && !wr_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_CMP;
        ST_CMP:  state <= ST_WRITE;
        ST_WRITE: begin
          if (wr_go) begin
            out_valid     <= 1'b1;
            out_rod_index <= index_q;
            asleep        <= res_flag;
            still_time    <= STILL_WIDTH'(CW'(res_timer));
            if (action_t'(action_q) == ACT_WAKE_ALL) begin
              clr_cnt <= '0;
              state   <= ST_CLEAR;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_reads, clk, rst, in_accept, state == ST_READ)
  `ASSERT_IMPLIES(a_write_states, clk, rst, ram_we, state == ST_WRITE || state == ST_CLEAR)
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, out_valid && out_stall, !wr_go)
  `ASSERT_NEXT(a_clear_holds, clk, rst, state == ST_CLEAR && clr_cnt != LAST_ADDR, in_stall)

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import rsd_pkg::*;

  localparam logic [1:0]  ACT_NONE = 2'd3;
  localparam logic [23:0] V_ZERO   = 24'h000000;
  localparam logic [23:0] V_MAX    = 24'h7FFFFF;
  localparam logic [23:0] V_MIN    = 24'h800000;
  localparam logic [23:0] V_ONE    = 24'h010000;
  localparam logic [23:0] V_NEG1   = 24'hFFFFFF;
  localparam int          SEGMENTS = 9;
  localparam int          SEG_BEATS = 210;

  typedef struct packed {
    logic [1:0]         act;
    logic [9:0]         idx;
    logic signed [23:0] vx, vy, vz, sx, sy, sz;
  } rod_beat_t;

  typedef struct packed {
    logic [9:0]  idx;
    logic        slp;
    logic [31:0] tim;
  } rod_report_t;

  typedef struct packed {
    rod_beat_t   beat;
    logic        typed;
    logic        slp;
    logic [31:0] tim;
  } dir_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 action = '0;
  logic [INDEX_WIDTH-1:0]     rod_index = '0;
  logic signed [23:0]         vel_x = '0, vel_y = '0, vel_z = '0;
  logic signed [23:0]         spin_x = '0, spin_y = '0, spin_z = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [INDEX_WIDTH-1:0]     out_rod_index;
  logic                       asleep;
  logic [STILL_WIDTH-1:0]     still_time;

  logic        beat_typed = 1'b0;
  logic        typed_slp = 1'b0;
  logic [31:0] typed_tim = '0;

  logic [10:0] cfg_rod_count = '0;
  logic [47:0] cfg_lin_limit = '0;
  logic [47:0] cfg_ang_limit = '0;
  logic [31:0] cfg_still_limit = '0;
  logic [15:0] cfg_time_step = '0;

  logic [1023:0] rod_live = '0;
  logic [1023:0] rod_asleep = '0;
  logic [31:0]   rod_timer [1024];

  rod_report_t pending_reports [$];
  int snd_idle_pct = 34;
  int rcv_idle_pct = 83;
  int mismatches = 0;
  int beats_in = 0;
  int reports_seen = 0;
  int sleep_reports = 0;
  int sweeps = 0;
  int phases = 0;

  dir_row_t dir_rows [21] = '{
    '{'{ACT_REST, 10'd0, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b1, 1'b0, 32'h4000},
    '{'{ACT_REST, 10'd0, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b1, 1'b0, 32'h8000},
    '{'{ACT_REST, 10'd0, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b1, 1'b1, 32'hC000},
    '{'{ACT_REST, 10'd0, V_MAX, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b1, 1'b0, 32'h0},
    '{'{ACT_REST, 10'd1, V_MIN, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b1, 1'b0, 32'h0},
    '{'{ACT_REST, 10'd1, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b1, 1'b0, 32'h4000},
    '{'{ACT_REST, 10'd1, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_MIN}, 1'b1, 1'b0, 32'h0},
    '{'{ACT_REST, 10'd1, 24'h00FFFF, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b0, 1'b0, 32'h0},
    '{'{ACT_REST, 10'd1, V_ONE, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b1, 1'b0, 32'h0},
    '{'{ACT_REST, 10'd2, V_ZERO, V_ZERO, V_ZERO, V_ONE, V_ZERO, V_ZERO}, 1'b1, 1'b0, 32'h0},
    '{'{ACT_REST, 10'd2, V_NEG1, V_NEG1, V_NEG1, 24'hFFF000, 24'hFFF000, 24'hFFF000},
      1'b0, 1'b0, 32'h0},
    '{'{ACT_WAKE, 10'd2, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b1, 1'b0, 32'h0},
    '{'{ACT_REST, 10'd8, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b1, 1'b0, 32'h0},
    '{'{ACT_WAKE, 10'd1023, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b1, 1'b0, 32'h0},
    '{'{ACT_NONE, 10'd1, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b0, 1'b0, 32'h0},
    '{'{ACT_REST, 10'd5, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b1, 1'b0, 32'h4000},
    '{'{ACT_WAKE_ALL, 10'd5, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b1, 1'b0, 32'h0},
    '{'{ACT_NONE, 10'd5, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b1, 1'b0, 32'h0},
    '{'{ACT_REST, 10'd5, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO, V_ZERO}, 1'b1, 1'b0, 32'h4000},
    '{'{ACT_REST, 10'd7, V_MAX, V_MAX, V_MIN, V_MIN, V_MAX, V_MIN}, 1'b1, 1'b0, 32'h0},
    '{'{ACT_REST, 10'd1023, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX}, 1'b1, 1'b0, 32'h0}
  };

  rest_sleep_detector_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .rod_index     (rod_index),
    .vel_x         (vel_x),
    .vel_y         (vel_y),
    .vel_z         (vel_z),
    .spin_x        (spin_x),
    .spin_y        (spin_y),
    .spin_z        (spin_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rod_index (out_rod_index),
    .asleep        (asleep),
    .still_time    (still_time)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [49:0] squared_speed(logic signed [23:0] a, logic signed [23:0] b,
                                                logic signed [23:0] c);
    logic signed [47:0] wa, wb, wc;
    logic [47:0] pa, pb, pc;
    wa = a;
    wb = b;
    wc = c;
    pa = wa * wa;
    pb = wb * wb;
    pc = wc * wc;
    return 50'(pa) + 50'(pb) + 50'(pc);
  endfunction

  function automatic rod_report_t next_rod_report(rod_beat_t b);
    logic [49:0] lin, ang;
    logic [32:0] grown;
    logic [31:0] t;
    logic        f;
    logic        in_use;
    rod_report_t r;
    in_use = {1'b0, b.idx} < cfg_rod_count;
    if (b.act == ACT_WAKE_ALL) begin
      rod_live = '0;
    end else if (in_use && b.act == ACT_WAKE) begin
      rod_live[b.idx] = 1'b1;
      rod_asleep[b.idx] = 1'b0;
      rod_timer[b.idx] = '0;
    end else if (in_use && b.act == ACT_REST) begin
      t = rod_live[b.idx] ? rod_timer[b.idx] : '0;
      f = rod_live[b.idx] ? rod_asleep[b.idx] : 1'b0;
      lin = squared_speed(b.vx, b.vy, b.vz);
      ang = squared_speed(b.sx, b.sy, b.sz);
      if (lin < cfg_lin_limit && ang < cfg_ang_limit) begin
        grown = {1'b0, t} + cfg_time_step;
        t = grown[32] ? '1 : grown[31:0];
        if (t >= cfg_still_limit) f = 1'b1;
      end else begin
        t = '0;
        f = 1'b0;
      end
      rod_live[b.idx] = 1'b1;
      rod_timer[b.idx] = t;
      rod_asleep[b.idx] = f;
    end
    r.idx = b.idx;
    r.slp = rod_live[b.idx] ? rod_asleep[b.idx] : 1'b0;
    r.tim = rod_live[b.idx] ? rod_timer[b.idx] : '0;
    return r;
  endfunction

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < rcv_idle_pct);
  end

  always @(posedge clk) begin
    rod_beat_t   b;
    rod_report_t want;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ROD_COUNT:   cfg_rod_count = cfg_data[10:0];
        CFG_LIN_LIMIT:   cfg_lin_limit = cfg_data;
        CFG_ANG_LIMIT:   cfg_ang_limit = cfg_data;
        CFG_STILL_LIMIT: cfg_still_limit = cfg_data[31:0];
        CFG_TIME_STEP:   cfg_time_step = cfg_data[15:0];
        default: ;
      endcase
    end
    if (!rst && in_valid && !in_stall) begin
      b = '{action, rod_index, vel_x, vel_y, vel_z, spin_x, spin_y, spin_z};
      want = next_rod_report(b);
      if (beat_typed) want = '{rod_index, typed_slp, typed_tim};
      pending_reports = {pending_reports, want};
      beats_in++;
      if (action == ACT_WAKE_ALL) sweeps++;
    end
    if (!rst && out_valid && !out_stall) begin
      reports_seen++;
      if (asleep === 1'b1) sleep_reports++;
      if (pending_reports.size() == 0) begin
        $error("result for rod %0d arrived with nothing pending", out_rod_index);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        if (out_rod_index !== want.idx) begin
          $error("out_rod_index: expected %0d, got %0d", want.idx, out_rod_index);
          mismatches++;
        end
        if (asleep !== want.slp) begin
          $error("asleep: expected %0d, got %0d", want.slp, asleep);
          mismatches++;
        end
        if (still_time !== want.tim) begin
          $error("still_time: expected %h, got %h", want.tim, still_time);
          mismatches++;
        end
      end
    end
  end

  task automatic send_beat(rod_beat_t b, logic typed = 1'b0, logic slp = 1'b0,
                           logic [31:0] tim = '0);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= b.act;
    rod_index <= b.idx;
    vel_x <= b.vx;
    vel_y <= b.vy;
    vel_z <= b.vz;
    spin_x <= b.sx;
    spin_y <= b.sy;
    spin_z <= b.sz;
    beat_typed <= typed;
    typed_slp <= slp;
    typed_tim <= tim;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // hold off until every result is back and the block has settled
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    do @(posedge clk); while (in_stall);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_regs(logic [10:0] cnt, logic [47:0] lin, logic [47:0] ang,
                            logic [31:0] still, logic [15:0] step);
    cfg_reg_t    regs [5];
    logic [47:0] vals [5];
    regs = '{CFG_ROD_COUNT, CFG_LIN_LIMIT, CFG_ANG_LIMIT, CFG_STILL_LIMIT, CFG_TIME_STEP};
    vals = '{48'(cnt), lin, ang, 48'(still), 48'(step)};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    phases++;
  endtask

  function automatic logic [47:0] draw_limit();
    return (48'd1 << $urandom_range(47, 26)) + 48'($urandom);
  endfunction

  function automatic logic signed [23:0] draw_speed();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 24'($urandom_range(8191)) - 24'd4096;
    if (r < 85) return 24'($urandom_range(131071)) - 24'd65536;
    return 24'($urandom);
  endfunction

  function automatic rod_beat_t draw_beat();
    rod_beat_t b;
    int r, lo, hi;
    r = $urandom_range(99);
    if (r < 85) b.act = ACT_REST;
    else if (r < 92) b.act = ACT_WAKE;
    else if (r < 97) b.act = ACT_NONE;
    else b.act = ACT_WAKE_ALL;
    r = $urandom_range(99);
    lo = int'(cfg_rod_count) - 2;
    hi = int'(cfg_rod_count) + 1;
    if (lo < 0) lo = 0;
    if (hi > 1023) hi = 1023;
    if (r < 40) b.idx = 10'($urandom_range(7));
    else if (r < 60) b.idx = 10'($urandom_range(hi, lo));
    else b.idx = 10'($urandom);
    b.vx = draw_speed();
    b.vy = draw_speed();
    b.vz = draw_speed();
    b.sx = draw_speed();
    b.sy = draw_speed();
    b.sz = draw_speed();
    return b;
  endfunction

  task automatic pick_setting(int seg);
    logic [15:0] step;
    logic [31:0] still;
    step = 16'($urandom_range(65535, 1));
    still = 32'(step) * 32'($urandom_range(8));
    case (seg)
      0, 7:    write_regs(11'd1024, draw_limit(), draw_limit(), still, step);
      1:       write_regs(11'd0, draw_limit(), draw_limit(), still, step);
      2:       write_regs(11'($urandom_range(1024, 1)), '0, draw_limit(), still, step);
      3:       write_regs(11'd1024, '1, '1, '0, '0);
      4:       write_regs(11'd16, draw_limit(), draw_limit(), '1, '1);
      5:       write_regs(11'($urandom_range(1023, 1)), draw_limit(), '0, still, step);
      6:       write_regs(11'd1024, 48'd1, '1, still, step);
      default: write_regs(11'($urandom_range(1024, 1)), draw_limit(), draw_limit(), still,
                          step);
    endcase
  endtask

  initial begin
    foreach (rod_timer[i]) rod_timer[i] = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    drain_pipe();
    write_regs(11'd8, 48'h1_0000_0000, 48'h1_0000_0000, 32'h0000_C000, 16'h4000);
    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].slp,
                                    dir_rows[i].tim);
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 3)
        0: begin snd_idle_pct = 34; rcv_idle_pct = 83; end
        1: begin snd_idle_pct = 83; rcv_idle_pct = 34; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      drain_pipe();
      pick_setting(seg);
      repeat (SEG_BEATS) send_beat(draw_beat());
    end
    drain_pipe();
    repeat (20) @(posedge clk);
    $display("Run covered %0d input beats over %0d register settings, %0d wake-all sweeps.",
             beats_in, phases, sweeps);
    $display("%0d results checked, %0d reporting a sleeping rod.",
             reports_seen, sleep_reports);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
